// File: rtl/circ_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle intersection package
// Shared widths, stage counts and the result status codes.
// ----------------------------------------------------------------------------
package circ_pkg;

   localparam int COORD_W = 32;
   localparam int LEN_W = 31;
   localparam int SQ_W = 2 * LEN_W;
   localparam int MAG_W = 63;
   localparam int DIV_A_STAGES = LEN_W;
   localparam int ROOT_STAGES = LEN_W;
   localparam int DIV_C_STAGES = MAG_W;

   typedef enum logic [1:0] {
      STATUS_REALIZED = 2'd0,
      STATUS_NO_MEET = 2'd1,
      STATUS_ZERO_BASE = 2'd2
   } status_type;

endpackage
`default_nettype wire

// File: rtl/circle_intersection_two_points.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle intersection of two base circles
// Places a third vertex at both intersections of two circles around the base
// points, with saturation and no-intersection / zero-base status.
// ----------------------------------------------------------------------------
// The pipeline takes one item per cycle while the result register is not stalled.
// The depth is set by the 63-stage coordinate dividers, the 31-stage divider
// for the offset along the base and the 31-stage square root, one bit per stage.
// A stalled result register holds the whole pipeline without loss.
// Synchronous reset clears all valid bits; the block is ready after reset.
module circle_intersection_two_points (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // base0_x, base0_y, base1_x, base1_y, base_length, radius_from_base0,
   // radius_from_base1, zero fill
   input  wire logic [223:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // first_x, first_y, second_x, second_y
   output logic      [127:0] rsp_tdata,
   // status, saturated
   output logic      [2:0]   rsp_tuser
);
   import circ_pkg::*;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      no_meet;
      logic                      zero_base;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W:0]   dx;
      logic signed [COORD_W:0]   dy;
      logic [LEN_W-1:0]          d;
      logic [SQ_W-1:0]           r0sq;
   } side_a_type;

   typedef struct packed {
      logic                      valid;
      logic                      no_meet;
      logic                      zero_base;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W:0]   dx;
      logic signed [COORD_W:0]   dy;
      logic [LEN_W-1:0]          d;
      logic signed [COORD_W-1:0] a;
   } side_r_type;

   typedef struct packed {
      logic                      valid;
      logic                      no_meet;
      logic                      zero_base;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic [3:0]                neg;
   } side_c_type;

   localparam int SUM_W = 66;

   logic enable;
   assign enable = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Stage 1: squares, base difference.
   logic signed [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
   logic [LEN_W-1:0]          in_d, in_r0, in_r1;
   assign in_x0 = req_tdata[31:0];
   assign in_y0 = req_tdata[63:32];
   assign in_x1 = req_tdata[95:64];
   assign in_y1 = req_tdata[127:96];
   assign in_d  = req_tdata[158:128];
   assign in_r0 = req_tdata[189:159];
   assign in_r1 = req_tdata[220:190];

   logic                      v1_ff;
   logic signed [COORD_W-1:0] x0_1_ff, y0_1_ff;
   logic signed [COORD_W:0]   dx_1_ff, dy_1_ff;
   logic [LEN_W-1:0]          d_1_ff;
   logic [SQ_W-1:0]           r0sq_1_ff, r1sq_1_ff, dsq_1_ff, dr0_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x0_1_ff <= in_x0;
         y0_1_ff <= in_y0;
         dx_1_ff <= (COORD_W+1)'(in_x1) - (COORD_W+1)'(in_x0);
         dy_1_ff <= (COORD_W+1)'(in_y1) - (COORD_W+1)'(in_y0);
         d_1_ff <= in_d;
         r0sq_1_ff <= SQ_W'(in_r0) * SQ_W'(in_r0);
         r1sq_1_ff <= SQ_W'(in_r1) * SQ_W'(in_r1);
         dsq_1_ff <= SQ_W'(in_d) * SQ_W'(in_d);
         dr0_1_ff <= SQ_W'(in_d) * SQ_W'(in_r0);
      end
   end

   // Stage 2: numerator, meeting test.
   logic signed [63:0] num_2;
   logic [MAG_W-1:0]   mag_2;
   assign num_2 = 64'(r0sq_1_ff) - 64'(r1sq_1_ff) + 64'(dsq_1_ff);
   assign mag_2 = num_2[63] ? MAG_W'(-num_2) : MAG_W'(num_2);

   side_a_type       side_a_in, side_a_ff, side_a_out;
   logic [MAG_W-1:0] mag_2_ff;

   assign side_a_in.valid = v1_ff;
   assign side_a_in.neg = num_2[63];
   assign side_a_in.no_meet = (mag_2 > {dr0_1_ff, 1'b0});
   assign side_a_in.zero_base = (d_1_ff == '0);
   assign side_a_in.x0 = x0_1_ff;
   assign side_a_in.y0 = y0_1_ff;
   assign side_a_in.dx = dx_1_ff;
   assign side_a_in.dy = dy_1_ff;
   assign side_a_in.d = d_1_ff;
   assign side_a_in.r0sq = r0sq_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff.valid <= 1'b0;
      end else if (enable) begin
         side_a_ff.valid <= side_a_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_a_ff.neg <= side_a_in.neg;
         side_a_ff.no_meet <= side_a_in.no_meet;
         side_a_ff.zero_base <= side_a_in.zero_base;
         side_a_ff.x0 <= side_a_in.x0;
         side_a_ff.y0 <= side_a_in.y0;
         side_a_ff.dx <= side_a_in.dx;
         side_a_ff.dy <= side_a_in.dy;
         side_a_ff.d <= side_a_in.d;
         side_a_ff.r0sq <= side_a_in.r0sq;
         mag_2_ff <= mag_2;
      end
   end

   // Offset a along the base: |num| / 2d.
   logic [LEN_W-1:0] a_mag;

   circ_div #(
      .NUM_W(MAG_W),
      .DEN_W(LEN_W + 1),
      .QUO_W(DIV_A_STAGES)
   ) u_div_a (
      .clock   (clock),
      .enable  (enable),
      .numer   (mag_2_ff),
      .denom   ({side_a_ff.d, 1'b0}),
      .quotient(a_mag)
   );

   circ_delay #(
      .WIDTH($bits(side_a_type)),
      .DEPTH(DIV_A_STAGES)
   ) u_delay_a (
      .clock (clock),
      .reset (reset),
      .enable(enable),
      .din   (side_a_ff),
      .dout  (side_a_out)
   );

   // Stage 3: signed a and its square.
   side_r_type    side_r3_ff;
   logic [SQ_W-1:0] r0sq_3_ff, asq_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_r3_ff.valid <= 1'b0;
      end else if (enable) begin
         side_r3_ff.valid <= side_a_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_r3_ff.no_meet <= side_a_out.no_meet;
         side_r3_ff.zero_base <= side_a_out.zero_base;
         side_r3_ff.x0 <= side_a_out.x0;
         side_r3_ff.y0 <= side_a_out.y0;
         side_r3_ff.dx <= side_a_out.dx;
         side_r3_ff.dy <= side_a_out.dy;
         side_r3_ff.d <= side_a_out.d;
         side_r3_ff.a <= side_a_out.neg ? -COORD_W'(a_mag) : COORD_W'(a_mag);
         r0sq_3_ff <= side_a_out.r0sq;
         asq_3_ff <= SQ_W'(a_mag) * SQ_W'(a_mag);
      end
   end

   // Stage 4: h squared.
   side_r_type      side_r4_ff, side_r_out;
   logic [SQ_W-1:0] hsq_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_r4_ff.valid <= 1'b0;
      end else if (enable) begin
         side_r4_ff.valid <= side_r3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_r4_ff.no_meet <= side_r3_ff.no_meet;
         side_r4_ff.zero_base <= side_r3_ff.zero_base;
         side_r4_ff.x0 <= side_r3_ff.x0;
         side_r4_ff.y0 <= side_r3_ff.y0;
         side_r4_ff.dx <= side_r3_ff.dx;
         side_r4_ff.dy <= side_r3_ff.dy;
         side_r4_ff.d <= side_r3_ff.d;
         side_r4_ff.a <= side_r3_ff.a;
         hsq_4_ff <= r0sq_3_ff - asq_3_ff;
      end
   end

   logic [LEN_W-1:0] h_root;

   circ_sqrt #(
      .RAD_W (SQ_W),
      .ROOT_W(ROOT_STAGES)
   ) u_sqrt (
      .clock   (clock),
      .enable  (enable),
      .radicand(hsq_4_ff),
      .root    (h_root)
   );

   circ_delay #(
      .WIDTH($bits(side_r_type)),
      .DEPTH(ROOT_STAGES)
   ) u_delay_r (
      .clock (clock),
      .reset (reset),
      .enable(enable),
      .din   (side_r4_ff),
      .dout  (side_r_out)
   );

   // Stage 5: the four products, split into sign and magnitude.
   logic signed [63:0] h_s;
   logic signed [63:0] prod [4];
   assign h_s = 64'(h_root);
   assign prod[0] = 64'(side_r_out.a) * 64'(side_r_out.dx);
   assign prod[1] = 64'(side_r_out.a) * 64'(side_r_out.dy);
   assign prod[2] = h_s * 64'(side_r_out.dy);
   assign prod[3] = h_s * 64'(side_r_out.dx);

   side_c_type       side_c_ff, side_c_out;
   logic [MAG_W-1:0] pmag_5_ff [4];
   logic [LEN_W-1:0] d_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_c_ff.valid <= 1'b0;
      end else if (enable) begin
         side_c_ff.valid <= side_r_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_c_ff.no_meet <= side_r_out.no_meet;
         side_c_ff.zero_base <= side_r_out.zero_base;
         side_c_ff.x0 <= side_r_out.x0;
         side_c_ff.y0 <= side_r_out.y0;
         d_5_ff <= side_r_out.d;
         for (int k = 0; k < 4; k++) begin
            side_c_ff.neg[k] <= prod[k][63];
            pmag_5_ff[k] <= prod[k][63] ? MAG_W'(-prod[k]) : MAG_W'(prod[k]);
         end
      end
   end

   logic [MAG_W-1:0] qmag [4];

   for (genvar k = 0; k < 4; k++) begin : g_div_c
      circ_div #(
         .NUM_W(MAG_W),
         .DEN_W(LEN_W),
         .QUO_W(DIV_C_STAGES)
      ) u_div_c (
         .clock   (clock),
         .enable  (enable),
         .numer   (pmag_5_ff[k]),
         .denom   (d_5_ff),
         .quotient(qmag[k])
      );
   end

   circ_delay #(
      .WIDTH($bits(side_c_type)),
      .DEPTH(DIV_C_STAGES)
   ) u_delay_c (
      .clock (clock),
      .reset (reset),
      .enable(enable),
      .din   (side_c_ff),
      .dout  (side_c_out)
   );

   // Stage 6: exact sums of base point, midpoint offset and chord offset.
   logic signed [SUM_W-1:0] q_s [4];
   for (genvar k = 0; k < 4; k++) begin : g_sign
      assign q_s[k] = side_c_out.neg[k] ? -SUM_W'(qmag[k]) : SUM_W'(qmag[k]);
   end

   logic                    v6_ff, no_meet_6_ff, zero_6_ff;
   logic signed [SUM_W-1:0] sum_6_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (enable) begin
         v6_ff <= side_c_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         no_meet_6_ff <= side_c_out.no_meet;
         zero_6_ff <= side_c_out.zero_base;
         sum_6_ff[0] <= SUM_W'(side_c_out.x0) + q_s[0] + q_s[2];
         sum_6_ff[1] <= SUM_W'(side_c_out.y0) + q_s[1] - q_s[3];
         sum_6_ff[2] <= SUM_W'(side_c_out.x0) + q_s[0] - q_s[2];
         sum_6_ff[3] <= SUM_W'(side_c_out.y0) + q_s[1] + q_s[3];
      end
   end

   // Stage 7: clamp and result register.
   localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] MIN_S = -SUM_W'(64'sh8000_0000);

   logic [COORD_W-1:0] coord_c [4];
   logic [3:0]         clip;
   for (genvar k = 0; k < 4; k++) begin : g_clamp
      always_comb begin
         clip[k] = 1'b0;
         coord_c[k] = COORD_W'(sum_6_ff[k]);
         if (sum_6_ff[k] > MAX_S) begin
            clip[k] = 1'b1;
            coord_c[k] = COORD_W'(MAX_S);
         end else if (sum_6_ff[k] < MIN_S) begin
            clip[k] = 1'b1;
            coord_c[k] = COORD_W'(MIN_S);
         end
      end
   end

   logic               rsp_valid_ff;
   logic [COORD_W-1:0] coord_ff [4];
   status_type         status_ff, status_in;
   logic               sat_ff;
   logic               fail;

   assign fail = zero_6_ff || no_meet_6_ff;

   always_comb begin
      if (zero_6_ff) begin
         status_in = STATUS_ZERO_BASE;
      end else if (no_meet_6_ff) begin
         status_in = STATUS_NO_MEET;
      end else begin
         status_in = STATUS_REALIZED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         status_ff <= status_in;
         sat_ff <= !fail && (clip != '0);
         for (int k = 0; k < 4; k++) begin
            coord_ff[k] <= fail ? '0 : coord_c[k];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {coord_ff[3], coord_ff[2], coord_ff[1], coord_ff[0]};
   assign rsp_tuser = {sat_ff, status_ff};
endmodule
`default_nettype wire

// File: rtl/circ_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle intersection delay line
// Carries side data and valid bits alongside a pipelined arithmetic unit.
// ----------------------------------------------------------------------------
module circ_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
`default_nettype wire

// File: rtl/circ_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle intersection divider
// Restoring unsigned divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module circ_div #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 32,
   parameter int QUO_W = 31
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic      [QUO_W-1:0] quotient
);
   localparam int EXT_W = NUM_W + DEN_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [EXT_W-1:0] rem_ext;
      logic [EXT_W-1:0] den_shift;
      logic             take;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = numer;
         assign den_prev = denom;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign rem_ext = EXT_W'(rem_prev);
      assign den_shift = EXT_W'(den_prev) << (QUO_W - 1 - s);
      assign take = (rem_ext >= den_shift);
      assign rem_in = take ? NUM_W'(rem_ext - den_shift) : rem_prev;
      assign quo_in = take ? (quo_prev | (QUO_W'(1) << (QUO_W - 1 - s))) : quo_prev;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];
endmodule
`default_nettype wire

// File: rtl/circ_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle intersection square root
// Truncating integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module circ_sqrt #(
   parameter int RAD_W = 62,
   parameter int ROOT_W = 31
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [RAD_W-1:0]  radicand,
   output logic      [ROOT_W-1:0] root
);
   localparam int TEST_W = RAD_W + 2;

   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - s;
      logic [RAD_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [TEST_W-1:0] trial;
      logic              take;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign rem_prev = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      // Growing the root by this bit adds 2*root*2^bit + 4^bit to its square.
      assign trial = (TEST_W'(root_prev) << (BIT + 1)) + (TEST_W'(1) << (2 * BIT));
      assign take = (TEST_W'(rem_prev) >= trial);
      assign rem_in = take ? RAD_W'(TEST_W'(rem_prev) - trial) : rem_prev;
      assign root_in = take ? (root_prev | (ROOT_W'(1) << BIT)) : root_prev;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];
endmodule
`default_nettype wire
